[src/rc4sc_pkg.sv]
// rc4sc_pkg: shared types and constants for the rc4 stream cipher block
// used by rc4sc_engine and rc4_stream_cipher; depends on nothing else

package rc4sc_pkg;

	localparam int BYTE_W  = 8;
	localparam int PERM_AW = 8;
	localparam int PERM_DEPTH = 256;

	// meaning of the item kind carried on tuser
	localparam logic CMD_KEY  = 1'b0;
	localparam logic CMD_DATA = 1'b1;

	// one access on the permutation memory: write enable, write address and data, read address
	typedef struct packed {
		logic               we;
		logic [PERM_AW-1:0] waddr;
		logic [BYTE_W-1:0]  wdata;
		logic [PERM_AW-1:0] raddr;
	} perm_req_t;

	// engine status seen by the top level
	typedef struct packed {
		logic key_busy;   // clearing sweep or key schedule running
		logic data_fin;   // last step of a data item
	} eng_status_t;

endpackage

[src/rc4sc_ram.sv]
// rc4sc_ram: generic single-write, single-read ram with registered read data
// write-first on a same-address read and write; no dependencies

module rc4sc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	clk,
	we,
	waddr,
	wdata,
	raddr,
	rdata
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	input  logic             clk;
	input  logic             we;
	input  logic [AW-1:0]    waddr;
	input  logic [WIDTH-1:0] wdata;
	input  logic [AW-1:0]    raddr;
	output logic [WIDTH-1:0] rdata;

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (we && (waddr == raddr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[src/rc4sc_engine.sv]
// rc4sc_engine: sequencer for key load, key schedule and keystream generation
// drives the permutation and key memories; uses rc4sc_pkg

module rc4sc_engine #(
	parameter int KEY_MAX = 256,
	localparam int KeyCw = $clog2(KEY_MAX + 1),
	localparam int KeyAw = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            in_cmd,
	input  logic [rc4sc_pkg::BYTE_W-1:0]    in_byte,
	input  logic                            in_last,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [rc4sc_pkg::BYTE_W-1:0]    out_byte,
	output logic                            out_last,
	output rc4sc_pkg::perm_req_t            perm_req,
	input  logic [rc4sc_pkg::BYTE_W-1:0]    perm_rdata,
	output logic                            key_we,
	output logic [KeyAw-1:0]                key_waddr,
	output logic [rc4sc_pkg::BYTE_W-1:0]    key_wdata,
	output logic [KeyAw-1:0]                key_raddr,
	input  logic [rc4sc_pkg::BYTE_W-1:0]    key_rdata,
	output rc4sc_pkg::eng_status_t          status
);
	localparam logic [KeyCw-1:0] KeyMaxC = KeyCw'(KEY_MAX);
	localparam logic [rc4sc_pkg::PERM_AW-1:0] LastIdx = '1;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_DJ,
		ST_DK,
		ST_DOUT,
		ST_KA,
		ST_KB,
		ST_KC,
		ST_KFIN
	} state_t;

	state_t                              state_q;
	logic                                sched_q;
	logic [rc4sc_pkg::PERM_AW-1:0]       cnt_q;
	logic [rc4sc_pkg::PERM_AW-1:0]       idx_i_q;
	logic [rc4sc_pkg::PERM_AW-1:0]       idx_j_q;
	logic [KeyCw-1:0]                    key_cnt_q;
	logic [KeyAw-1:0]                    kidx_q;
	logic                                pend_q;
	logic [rc4sc_pkg::BYTE_W-1:0]        si_q;
	logic [rc4sc_pkg::BYTE_W-1:0]        sj_q;
	logic [rc4sc_pkg::BYTE_W-1:0]        byte_q;
	logic                                last_q;
	logic                                out_valid_q;
	logic [rc4sc_pkg::BYTE_W-1:0]        out_byte_q;
	logic                                out_last_q;

	logic                                out_free;
	logic                                accept;
	logic                                key_room;
	logic [rc4sc_pkg::PERM_AW-1:0]       i_next;
	logic [rc4sc_pkg::PERM_AW-1:0]       j_data;
	logic [rc4sc_pkg::PERM_AW-1:0]       j_sched;
	logic [rc4sc_pkg::PERM_AW-1:0]       t_addr;
	logic [rc4sc_pkg::BYTE_W-1:0]        ks_byte;
	logic [KeyAw-1:0]                    kidx_next;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) || ((state_q == ST_DOUT) && out_free);
	assign accept   = in_valid && in_ready;
	assign key_room = key_cnt_q < KeyMaxC;

	assign i_next  = idx_i_q + 8'd1;
	assign j_data  = idx_j_q + perm_rdata;
	assign j_sched = idx_j_q + perm_rdata + key_rdata;
	assign t_addr  = si_q + sj_q;

	// post-swap values of the two swapped entries win over the memory read
	always_comb begin
		if (t_addr == idx_j_q) begin
			ks_byte = si_q;
		end else if (t_addr == idx_i_q) begin
			ks_byte = sj_q;
		end else begin
			ks_byte = perm_rdata;
		end
	end

	assign kidx_next = ((KeyCw'(kidx_q) + KeyCw'(1)) == key_cnt_q) ? '0 : kidx_q + KeyAw'(1);

	// memory port requests
	always_comb begin
		perm_req.we    = 1'b0;
		perm_req.waddr = idx_j_q;
		perm_req.wdata = si_q;
		perm_req.raddr = i_next;
		case (state_q)
			ST_CLR: begin
				perm_req.we    = 1'b1;
				perm_req.waddr = cnt_q;
				perm_req.wdata = cnt_q;
			end
			ST_IDLE: begin
				perm_req.raddr = i_next;
			end
			ST_DJ: begin
				perm_req.raddr = j_data;
			end
			ST_DK: begin
				perm_req.we    = 1'b1;
				perm_req.waddr = idx_i_q;
				perm_req.wdata = perm_rdata;
				perm_req.raddr = si_q + perm_rdata;
			end
			ST_DOUT: begin
				perm_req.we    = 1'b1;
				perm_req.waddr = idx_j_q;
				perm_req.wdata = si_q;
				perm_req.raddr = accept ? i_next : t_addr;
			end
			ST_KA: begin
				perm_req.we    = pend_q;
				perm_req.waddr = idx_j_q;
				perm_req.wdata = si_q;
				perm_req.raddr = cnt_q;
			end
			ST_KB: begin
				perm_req.raddr = j_sched;
			end
			ST_KC: begin
				perm_req.we    = 1'b1;
				perm_req.waddr = cnt_q;
				perm_req.wdata = perm_rdata;
			end
			ST_KFIN: begin
				perm_req.we    = 1'b1;
				perm_req.waddr = idx_j_q;
				perm_req.wdata = si_q;
			end
			default: begin
				perm_req.we = 1'b0;
			end
		endcase
	end

	assign key_we    = accept && (in_cmd == rc4sc_pkg::CMD_KEY) && key_room;
	assign key_waddr = key_cnt_q[KeyAw-1:0];
	assign key_wdata = in_byte;
	assign key_raddr = kidx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			sched_q     <= 1'b0;
			cnt_q       <= '0;
			idx_i_q     <= '0;
			idx_j_q     <= '0;
			key_cnt_q   <= '0;
			kidx_q      <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					cnt_q <= cnt_q + 8'd1;
					if (cnt_q == LastIdx) begin
						if (sched_q) begin
							state_q <= ST_KA;
							idx_j_q <= '0;
							kidx_q  <= '0;
							pend_q  <= 1'b0;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_DJ: begin
					si_q    <= perm_rdata;
					idx_j_q <= j_data;
					state_q <= ST_DK;
				end
				ST_DK: begin
					sj_q    <= perm_rdata;
					state_q <= ST_DOUT;
				end
				ST_KA: begin
					state_q <= ST_KB;
				end
				ST_KB: begin
					si_q    <= perm_rdata;
					idx_j_q <= j_sched;
					state_q <= ST_KC;
				end
				ST_KC: begin
					pend_q <= 1'b1;
					cnt_q  <= cnt_q + 8'd1;
					kidx_q <= kidx_next;
					if (cnt_q == LastIdx) begin
						state_q <= ST_KFIN;
					end else begin
						state_q <= ST_KA;
					end
				end
				ST_KFIN: begin
					idx_i_q   <= '0;
					idx_j_q   <= '0;
					key_cnt_q <= '0;
					sched_q   <= 1'b0;
					state_q   <= ST_IDLE;
				end
				default: begin
					// idle and final data step: result hand-off and intake
					if (state_q == ST_DOUT) begin
						if (out_free) begin
							out_valid_q <= 1'b1;
							out_byte_q  <= byte_q ^ ks_byte;
							out_last_q  <= last_q;
							state_q     <= ST_IDLE;
						end
					end
					if (accept) begin
						if (in_cmd == rc4sc_pkg::CMD_DATA) begin
							idx_i_q <= i_next;
							byte_q  <= in_byte;
							last_q  <= in_last;
							state_q <= ST_DJ;
						end else begin
							if (key_room) begin
								key_cnt_q <= key_cnt_q + KeyCw'(1);
							end
							if (in_last) begin
								sched_q <= 1'b1;
								cnt_q   <= '0;
								state_q <= ST_CLR;
							end else begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

	assign status.key_busy = (state_q == ST_CLR) || (state_q == ST_KA) || (state_q == ST_KB)
		|| (state_q == ST_KC) || (state_q == ST_KFIN);
	assign status.data_fin = (state_q == ST_DOUT);

endmodule

[src/rc4_stream_cipher.sv]
// rc4_stream_cipher: top level of the rc4 cipher block
// instantiates rc4sc_engine and two rc4sc_ram memories; uses rc4sc_pkg
//
// usage:
// - input channel s_*: one byte per item on s_tdata, item kind on s_tuser
//   (key byte or data byte), s_tlast marks the last key byte or last data byte
// - key bytes give no result; the last key byte starts the key schedule
// - each data byte gives one item on m_* with the byte xor keystream,
//   m_tlast copies the input flag
// - a data byte passes the read, swap and lookup steps (ST_DJ, ST_DK, ST_DOUT) on the
//   permutation memory port before its result reaches the output register; the next
//   item is taken only in the last step, as the result is handed to the output register
// - a key byte returns the engine straight to idle; the last key byte adds a sweep that
//   loads the identity permutation, then one swap per index (ST_KA, ST_KB, ST_KC) and ST_KFIN
// - after reset the same sweep runs before s_tready goes high;
//   indices and key count start at zero
// - when m_tready is low the finished result waits in the output register,
//   the next data byte is held in its last step and s_tready drops

module rc4_stream_cipher #(
	parameter int KEY_MAX = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,    // byte_in
	input  logic [0:0] s_tuser,    // cmd
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,    // byte_out
	output logic       m_tlast
);
	localparam int KeyAw = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

	rc4sc_pkg::perm_req_t               perm_req;
	rc4sc_pkg::eng_status_t             status;
	logic [rc4sc_pkg::BYTE_W-1:0]       perm_rdata;
	logic                               key_we;
	logic [KeyAw-1:0]                   key_waddr;
	logic [rc4sc_pkg::BYTE_W-1:0]       key_wdata;
	logic [KeyAw-1:0]                   key_raddr;
	logic [rc4sc_pkg::BYTE_W-1:0]       key_rdata;

	rc4sc_engine #(
		.KEY_MAX(KEY_MAX)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (s_tuser[0]),
		.in_byte   (s_tdata),
		.in_last   (s_tlast),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_last  (m_tlast),
		.perm_req  (perm_req),
		.perm_rdata(perm_rdata),
		.key_we    (key_we),
		.key_waddr (key_waddr),
		.key_wdata (key_wdata),
		.key_raddr (key_raddr),
		.key_rdata (key_rdata),
		.status    (status)
	);

	rc4sc_ram #(
		.WIDTH(rc4sc_pkg::BYTE_W),
		.DEPTH(rc4sc_pkg::PERM_DEPTH)
	) u_perm_ram (
		.clk  (clk),
		.we   (perm_req.we),
		.waddr(perm_req.waddr),
		.wdata(perm_req.wdata),
		.raddr(perm_req.raddr),
		.rdata(perm_rdata)
	);

	rc4sc_ram #(
		.WIDTH(rc4sc_pkg::BYTE_W),
		.DEPTH(KEY_MAX)
	) u_key_ram (
		.clk  (clk),
		.we   (key_we),
		.waddr(key_waddr),
		.wdata(key_wdata),
		.raddr(key_raddr),
		.rdata(key_rdata)
	);

	// no intake while the permutation is being rebuilt
	a_busy_blocks_intake: assert property (@(posedge clk) disable iff (!arst_n)
		status.key_busy |-> !s_tready)
		else $error("item taken during key schedule");

	// a new result only comes out of the final data step
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(status.data_fin))
		else $error("result appeared outside the final data step");

	// a data item holds off intake for its two memory read steps
	a_data_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser[0] == rc4sc_pkg::CMD_DATA))
		|=> !s_tready ##1 !s_tready)
		else $error("data item overlapped the previous one");

	// a data item never starts a schedule
	a_data_no_sched: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser[0] == rc4sc_pkg::CMD_DATA))
		|=> !status.key_busy)
		else $error("data item started the key schedule");

endmodule

[tb/tb_rc4_stream_cipher.sv]
`timescale 1ns / 1ps
// tb_rc4_stream_cipher: self-checking testbench for the rc4 stream cipher block
// keeps its own copy of the rc4 state to predict each output byte; needs rc4sc_pkg
// and rc4_stream_cipher

module tb_rc4_stream_cipher;

	localparam int KEY_MAX       = 256;
	localparam int IDLE_PCT      = 21;
	localparam int SETTLE_CYCLES = 1100;   // a full key schedule plus margin
	localparam int RANDOM_ITEMS  = 250;

	typedef struct {
		logic [7:0] text;
		logic       fin;
	} cipher_out_t;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;    // byte_in
	logic [0:0] s_tuser;    // cmd
	logic       s_tlast;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;    // byte_out
	logic       m_tlast;

	// predicted cipher output, oldest first
	cipher_out_t cipher_out_q[$];

	// rc4 state as the predictor sees it
	logic [7:0] perm_m [256];
	logic [7:0] key_m [256];
	int         key_len;
	logic [7:0] ks_i;
	logic [7:0] ks_j;

	int err_count  = 0;
	int items_sent = 0;
	bit idle_on    = 1'b1;
	int hold_left  = 0;

	rc4_stream_cipher #(
		.KEY_MAX(KEY_MAX)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic void rc4_state_reset();
		for (int n = 0; n < 256; n++) begin
			perm_m[n] = 8'(n);
			key_m[n]  = 8'h00;
		end
		key_len = 0;
		ks_i    = 8'h00;
		ks_j    = 8'h00;
	endfunction

	function automatic void run_key_schedule();
		logic [7:0] j;
		logic [7:0] t;
		int         len;
		j   = 8'h00;
		len = (key_len == 0) ? 1 : key_len;
		for (int n = 0; n < 256; n++)
			perm_m[n] = 8'(n);
		for (int n = 0; n < 256; n++) begin
			j         = j + perm_m[n] + key_m[n % len];
			t         = perm_m[n];
			perm_m[n] = perm_m[j];
			perm_m[j] = t;
		end
		ks_i    = 8'h00;
		ks_j    = 8'h00;
		key_len = 0;
	endfunction

	// advance the rc4 state by one accepted item, queue the output it causes
	function automatic void rc4_absorb(logic cmd, logic [7:0] b, logic fin);
		logic [7:0] t;
		logic [7:0] sum;
		if (cmd == rc4sc_pkg::CMD_KEY) begin
			if (key_len < KEY_MAX) begin
				key_m[key_len] = b;
				key_len++;
			end
			if (fin)
				run_key_schedule();
		end else begin
			ks_i         = ks_i + 8'd1;
			ks_j         = ks_j + perm_m[ks_i];
			t            = perm_m[ks_i];
			perm_m[ks_i] = perm_m[ks_j];
			perm_m[ks_j] = t;
			sum          = perm_m[ks_i] + perm_m[ks_j];
			cipher_out_q.push_back('{text: b ^ perm_m[sum], fin: fin});
		end
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		err_count++;
	endtask

	// called at a falling edge, returns at a falling edge with the item taken
	task automatic send_item(logic cmd, logic [7:0] b, logic fin);
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= cmd;
		s_tlast  <= fin;
		do
			@(posedge clk);
		while (!s_tready);
		rc4_absorb(cmd, b, fin);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (cipher_out_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic send_key(int len);
		for (int n = 0; n < len; n++)
			send_item(rc4sc_pkg::CMD_KEY, 8'($urandom_range(255)), n == len - 1);
	endtask

	task automatic send_message(int len);
		for (int n = 0; n < len; n++)
			send_item(rc4sc_pkg::CMD_DATA, 8'($urandom_range(255)), n == len - 1);
	endtask

	// keystream straight from the identity permutation left by reset
	task automatic test_stream_before_key();
		send_item(rc4sc_pkg::CMD_DATA, 8'h00, 1'b0);
		send_item(rc4sc_pkg::CMD_DATA, 8'hff, 1'b0);
		send_item(rc4sc_pkg::CMD_DATA, 8'h5a, 1'b1);
		send_item(rc4sc_pkg::CMD_DATA, 8'ha5, 1'b0);
		send_item(rc4sc_pkg::CMD_DATA, 8'h00, 1'b1);
	endtask

	// one-byte keys at both byte extremes and a three-byte key, keystream runs across messages
	task automatic test_short_keys();
		send_item(rc4sc_pkg::CMD_KEY, 8'hff, 1'b1);
		send_item(rc4sc_pkg::CMD_DATA, 8'h00, 1'b0);
		send_item(rc4sc_pkg::CMD_DATA, 8'hff, 1'b1);
		send_item(rc4sc_pkg::CMD_DATA, 8'h81, 1'b1);
		send_item(rc4sc_pkg::CMD_KEY, 8'h00, 1'b1);
		send_item(rc4sc_pkg::CMD_DATA, 8'h7e, 1'b0);
		send_item(rc4sc_pkg::CMD_DATA, 8'hff, 1'b1);
		send_item(rc4sc_pkg::CMD_KEY, 8'h01, 1'b0);
		send_item(rc4sc_pkg::CMD_KEY, 8'h80, 1'b0);
		send_item(rc4sc_pkg::CMD_KEY, 8'hfe, 1'b1);
		send_message(4);
	endtask

	// key bytes past KEY_MAX are dropped but the last flag still starts the schedule
	task automatic test_key_overflow();
		send_key(KEY_MAX + 2);
		send_message(8);
	endtask

	// receiver holds off while data keeps coming, then the sender waits for all output; a rekeyed message follows
	task automatic test_backpressure();
		hold_left = 200;
		send_message(40);
		wait_drained();
		send_key(5);
		send_message(6);
		wait_drained();
	endtask

	task automatic test_random_traffic();
		int stop_at;
		int round;
		stop_at = items_sent + RANDOM_ITEMS;
		round   = 0;
		while (items_sent < stop_at) begin
			// a long stretch without idling on either side
			idle_on = !(round >= 3 && round < 9);
			if ($urandom_range(99) < 85) begin
				if ($urandom_range(9) == 0)
					send_key($urandom_range(KEY_MAX + 2, 17));
				else
					send_key($urandom_range(16, 1));
				send_message($urandom_range(24, 1));
			end else begin
				repeat ($urandom_range(6, 1))
					send_item(1'($urandom_range(1)), 8'($urandom_range(255)),
						$urandom_range(3) == 0);
			end
			round++;
		end
		idle_on = 1'b1;
	endtask

	// receiver side: random stalls plus an occasional long hold-off
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		cipher_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (cipher_out_q.size() == 0) begin
				report_mismatch("unexpected item", int'(m_tdata), 0);
			end else begin
				want = cipher_out_q.pop_front();
				if (m_tdata !== want.text)
					report_mismatch("m_tdata", int'(m_tdata), int'(want.text));
				if (m_tlast !== want.fin)
					report_mismatch("m_tlast", int'(m_tlast), int'(want.fin));
			end
		end
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = 8'h00;
		s_tuser  = rc4sc_pkg::CMD_KEY;
		s_tlast  = 1'b0;
		rc4_state_reset();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_stream_before_key();
		test_short_keys();
		test_key_overflow();
		test_backpressure();
		test_random_traffic();

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
